>>> hw/rtl/lc3b_pkg.sv
package lc3b_pkg;

	localparam int MemWords = 32768;
	localparam int MemAw = $clog2(MemWords);
	localparam int ClearCycles = MemWords;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_EXEC  = 2'd1;
	localparam logic [1:0] CMD_SETPC = 2'd2;

	localparam logic [3:0] OP_BR   = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_LDB  = 4'd2;
	localparam logic [3:0] OP_STB  = 4'd3;
	localparam logic [3:0] OP_AND  = 4'd5;
	localparam logic [3:0] OP_LDW  = 4'd6;
	localparam logic [3:0] OP_LEA  = 4'd14;
	localparam logic [3:0] OP_TRAP = 4'd15;

	// byte address to memory word index, wrapping on the memory depth
	function automatic logic [MemAw-1:0] word_idx(input logic [15:0] a);
		logic [14:0] w;
		w = a[15:1];
		return w[MemAw-1:0];
	endfunction

endpackage

>>> hw/rtl/lc3b_mem.sv
// Byte-lane memory, one port, registered read data.
module lc3b_mem (
	input  logic                      clk,
	input  logic                      en,
	input  logic [1:0]                we,
	input  logic [lc3b_pkg::MemAw-1:0] addr,
	input  logic [15:0]               wdata,
	output logic [15:0]               rdata
);
	logic [7:0] lo_mem [lc3b_pkg::MemWords];
	logic [7:0] hi_mem [lc3b_pkg::MemWords];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we[0]) lo_mem[addr] <= wdata[7:0];
			if (we[1]) hi_mem[addr] <= wdata[15:8];
			rdata <= {hi_mem[addr], lo_mem[addr]};
		end
	end
endmodule

>>> hw/rtl/lc3b_subset_execute_step.sv
// LC-3b subset execute step.
// Commands arrive on start/command/address/data_word and are taken when
// start is high and busy is low. Command 0 writes a memory word, command 2
// sets the PC (condition codes back to Z), command 1 executes one
// instruction at the PC (ADD, AND, BR, LDB, STB, LDW, LEA, TRAP; other
// opcodes advance the PC by 2). An execute with PC zero halts.
// Every word taken returns exactly one result word, marked by done for one
// cycle; the receiver cannot stall, so results never back up.
// A write, set-PC or halt goes through ST_DONE before done. An execute
// does its fetch read in ST_FETCH, then one data or trap-vector read and
// writeback in ST_DATA, or retires from ST_FETCH without a data read.
// Busy stays high from acceptance until done, so one word is in work at a
// time; the single memory port sets the pace.
// After reset the memory is cleared one word a cycle, all 32768 words;
// busy is high during that sweep. Registers reset to zero, PC to zero,
// condition codes to Z.
module lc3b_subset_execute_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [15:0] address,
	input  logic [15:0] data_word,
	output logic        done,
	output logic [15:0] program_counter,
	output logic        flag_negative,
	output logic        flag_zero,
	output logic        flag_positive,
	output logic        reg_write_valid,
	output logic [2:0]  reg_write_index,
	output logic [15:0] reg_write_value,
	output logic        store_valid,
	output logic [15:0] store_address,
	output logic [7:0]  store_byte,
	output logic        halted
);
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_DATA  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]  state_q;
	logic [lc3b_pkg::MemAw:0] clr_q;
	logic [15:0] regs_q [8];
	logic [15:0] pc_q;
	logic [2:0]  cc_q;
	logic [15:0] ins_q, ea_q;
	logic [1:0]  cmd_q;

	logic        m_en;
	logic [1:0]  m_we;
	logic [lc3b_pkg::MemAw-1:0] m_addr;
	logic [15:0] m_wdata, m_rdata;

	lc3b_mem u_mem (
		.clk(clk), .en(m_en), .we(m_we), .addr(m_addr),
		.wdata(m_wdata), .rdata(m_rdata)
	);

	// decode of the fetched word (valid in ST_FETCH) or held word
	logic [15:0] ins;
	logic [3:0]  op;
	logic [2:0]  f119, f86;
	logic [15:0] s5, s6, s9, pc2;
	assign ins  = (state_q == ST_FETCH) ? m_rdata : ins_q;
	assign op   = ins[15:12];
	assign f119 = ins[11:9];
	assign f86  = ins[8:6];
	assign s5   = {{11{ins[4]}}, ins[4:0]};
	assign s6   = {{10{ins[5]}}, ins[5:0]};
	assign s9   = {{7{ins[8]}}, ins[8:0]};
	assign pc2  = pc_q + 16'd2;

	logic [15:0] ea_ldb, ea_stb, ea_ldw, trapv;
	assign ea_ldb = regs_q[f119] + s6;
	assign ea_stb = regs_q[f86] + s6;
	assign ea_ldw = regs_q[f86] + {s6[14:0], 1'b0};
	assign trapv  = {7'd0, ins[7:0], 1'b0};

	// memory port control
	always_comb begin
		m_en = 1'b0;
		m_we = 2'b00;
		m_addr = '0;
		m_wdata = data_word;
		case (state_q)
			ST_CLEAR: begin
				m_en = 1'b1;
				m_we = 2'b11;
				m_addr = clr_q[lc3b_pkg::MemAw-1:0];
				m_wdata = '0;
			end
			ST_IDLE: begin
				if (start) begin
					m_en = 1'b1;
					if (command == lc3b_pkg::CMD_WRITE) begin
						m_we = 2'b11;
						m_addr = lc3b_pkg::word_idx(address);
					end else begin
						m_addr = lc3b_pkg::word_idx(pc_q);
					end
				end
			end
			ST_FETCH: begin
				m_en = 1'b1;
				case (op)
					lc3b_pkg::OP_LDB: m_addr = lc3b_pkg::word_idx(ea_ldb);
					lc3b_pkg::OP_LDW: m_addr = lc3b_pkg::word_idx(ea_ldw);
					lc3b_pkg::OP_TRAP: m_addr = lc3b_pkg::word_idx(trapv);
					lc3b_pkg::OP_STB: begin
						m_addr = lc3b_pkg::word_idx(ea_stb);
						m_we = ea_stb[0] ? 2'b10 : 2'b01;
						m_wdata = {regs_q[f119][7:0], regs_q[f119][7:0]};
					end
					default: m_en = 1'b0;
				endcase
			end
			default: ;
		endcase
	end

	// writeback result of the current execute
	logic        wv;
	logic [2:0]  wi;
	logic [15:0] wval, npc;
	logic        setcc;
	always_comb begin
		wv = 1'b0; wi = '0; wval = '0; npc = pc2; setcc = 1'b1;
		case (op)
			lc3b_pkg::OP_ADD: begin
				wv = 1'b1; wi = f119;
				wval = regs_q[f86] + (ins[5] ? s5 : regs_q[ins[2:0]]);
			end
			lc3b_pkg::OP_AND: begin
				wv = 1'b1; wi = f119;
				wval = regs_q[f86] & (ins[5] ? s5 : regs_q[ins[2:0]]);
			end
			lc3b_pkg::OP_BR: begin
				if ((f119 & cc_q) != 3'd0) npc = pc2 + {s9[14:0], 1'b0};
			end
			lc3b_pkg::OP_LDB: begin
				wv = 1'b1; wi = f86;
				wval = ea_q[0] ? {{8{m_rdata[15]}}, m_rdata[15:8]}
				               : {{8{m_rdata[7]}}, m_rdata[7:0]};
			end
			lc3b_pkg::OP_LDW: begin
				wv = 1'b1; wi = f119; wval = m_rdata;
			end
			lc3b_pkg::OP_LEA: begin
				wv = 1'b1; wi = f119; wval = pc2 + {s9[14:0], 1'b0};
			end
			lc3b_pkg::OP_TRAP: begin
				wv = 1'b1; wi = 3'd7; wval = pc2; npc = m_rdata; setcc = 1'b0;
			end
			default: ;
		endcase
	end

	logic [2:0] cc_new;
	assign cc_new = (wval == 16'd0) ? 3'b010 : (wval[15] ? 3'b100 : 3'b001);

	logic needs_data;
	assign needs_data = (op == lc3b_pkg::OP_LDB) || (op == lc3b_pkg::OP_LDW)
		|| (op == lc3b_pkg::OP_TRAP);

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			pc_q <= '0;
			cc_q <= 3'b010;
			ins_q <= '0;
			ea_q <= '0;
			cmd_q <= '0;
			done <= 1'b0;
			program_counter <= '0;
			{flag_negative, flag_zero, flag_positive} <= 3'b010;
			reg_write_valid <= 1'b0;
			reg_write_index <= '0;
			reg_write_value <= '0;
			store_valid <= 1'b0;
			store_address <= '0;
			store_byte <= '0;
			halted <= 1'b0;
			for (int i = 0; i < 8; i++) regs_q[i] <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (lc3b_pkg::MemAw+1)'(lc3b_pkg::ClearCycles - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q <= command;
						if (command == lc3b_pkg::CMD_SETPC) begin
							pc_q <= address;
							cc_q <= 3'b010;
						end
						state_q <= (command == lc3b_pkg::CMD_EXEC && pc_q != 16'd0)
							? ST_FETCH : ST_DONE;
					end
				end
				ST_FETCH: begin
					ins_q <= m_rdata;
					ea_q <= (op == lc3b_pkg::OP_LDB) ? ea_ldb : ea_stb;
					if (needs_data) begin
						state_q <= ST_DATA;
					end else begin
						// retire now: no data read needed
						pc_q <= npc;
						if (wv) begin
							regs_q[wi] <= wval;
							if (setcc) cc_q <= cc_new;
						end
						done <= 1'b1;
						program_counter <= npc;
						{flag_negative, flag_zero, flag_positive} <=
							(wv && setcc) ? cc_new : cc_q;
						reg_write_valid <= wv;
						reg_write_index <= wi;
						reg_write_value <= wval;
						store_valid <= (op == lc3b_pkg::OP_STB);
						store_address <= (op == lc3b_pkg::OP_STB) ? ea_stb : '0;
						store_byte <= (op == lc3b_pkg::OP_STB) ? regs_q[f119][7:0] : '0;
						halted <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_DATA: begin
					pc_q <= npc;
					regs_q[wi] <= wval;
					if (setcc) cc_q <= cc_new;
					done <= 1'b1;
					program_counter <= npc;
					{flag_negative, flag_zero, flag_positive} <= setcc ? cc_new : cc_q;
					reg_write_valid <= 1'b1;
					reg_write_index <= wi;
					reg_write_value <= wval;
					store_valid <= 1'b0;
					store_address <= '0;
					store_byte <= '0;
					halted <= 1'b0;
					state_q <= ST_IDLE;
				end
				ST_DONE: begin
					// write, set-PC, halt or unused command: report state
					done <= 1'b1;
					program_counter <= pc_q;
					{flag_negative, flag_zero, flag_positive} <= cc_q;
					reg_write_valid <= 1'b0;
					reg_write_index <= '0;
					reg_write_value <= '0;
					store_valid <= 1'b0;
					store_address <= '0;
					store_byte <= '0;
					halted <= (cmd_q == lc3b_pkg::CMD_EXEC);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lc3b_pkg::*;

	// one result word as the core reports it
	typedef struct packed {
		logic [15:0] pc;
		logic        n;
		logic        z;
		logic        p;
		logic        wr_valid;
		logic [2:0]  wr_index;
		logic [15:0] wr_value;
		logic        st_valid;
		logic [15:0] st_address;
		logic [7:0]  st_byte;
		logic        halt;
	} step_result_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] addr;
		logic [15:0] data;
	} command_word_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [15:0] address;
	logic [15:0] data_word;
	logic        done;
	logic [15:0] program_counter;
	logic        flag_negative;
	logic        flag_zero;
	logic        flag_positive;
	logic        reg_write_valid;
	logic [2:0]  reg_write_index;
	logic [15:0] reg_write_value;
	logic        store_valid;
	logic [15:0] store_address;
	logic [7:0]  store_byte;
	logic        halted;

	lc3b_subset_execute_step i_dut (.*);

	// shadow of the core's architectural state
	logic [7:0]  shadow_lo [MemWords];
	logic [7:0]  shadow_hi [MemWords];
	logic [15:0] shadow_regs [8];
	logic [15:0] shadow_pc;
	logic [2:0]  shadow_nzp;

	command_word_t pending_words [$];
	step_result_t  expected_results [$];
	int            failures;
	int            cycles;
	bit            calm;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [15:0] sign_ext(input logic [15:0] v, input int bits);
		logic [15:0] r;
		for (int i = 0; i < 16; i++)
			r[i] = (i < bits) ? v[i] : v[bits-1];
		return r;
	endfunction

	function automatic logic [15:0] fetch_word(input logic [15:0] a);
		int w;
		w = int'(a[15:1]) % MemWords;
		return {shadow_hi[w], shadow_lo[w]};
	endfunction

	function automatic logic [2:0] nzp_of(input logic [15:0] v);
		if (v == 16'd0)
			return 3'b010;
		return v[15] ? 3'b100 : 3'b001;
	endfunction

	// advance the shadow state by one word and return what the core must report
	function automatic step_result_t predict_step(input command_word_t cw);
		step_result_t r;
		logic [15:0] ins, pc2, ea, val;
		logic [3:0]  op;
		logic [2:0]  f119, f86;
		int          w;
		r = '0;
		if (cw.cmd == CMD_WRITE) begin
			w = int'(cw.addr[15:1]) % MemWords;
			shadow_lo[w] = cw.data[7:0];
			shadow_hi[w] = cw.data[15:8];
		end else if (cw.cmd == CMD_SETPC) begin
			shadow_pc = cw.addr;
			shadow_nzp = 3'b010;
		end else if (cw.cmd == CMD_EXEC) begin
			if (shadow_pc == 16'd0) begin
				r.halt = 1'b1;
			end else begin
				ins = fetch_word(shadow_pc);
				op = ins[15:12];
				pc2 = shadow_pc + 16'd2;
				f119 = ins[11:9];
				f86 = ins[8:6];
				shadow_pc = pc2;
				case (op)
					OP_ADD, OP_AND: begin
						val = ins[5] ? sign_ext(ins, 5) : shadow_regs[ins[2:0]];
						val = (op == OP_ADD) ? shadow_regs[f86] + val : shadow_regs[f86] & val;
						r.wr_valid = 1'b1; r.wr_index = f119; r.wr_value = val;
					end
					OP_BR: begin
						if ((f119 & shadow_nzp) != 3'b000)
							shadow_pc = pc2 + (sign_ext(ins, 9) << 1);
					end
					OP_LDB: begin
						ea = shadow_regs[f119] + sign_ext(ins, 6);
						w = int'(ea[15:1]) % MemWords;
						val = {8'h00, ea[0] ? shadow_hi[w] : shadow_lo[w]};
						r.wr_valid = 1'b1; r.wr_index = f86; r.wr_value = sign_ext(val, 8);
					end
					OP_STB: begin
						ea = shadow_regs[f86] + sign_ext(ins, 6);
						w = int'(ea[15:1]) % MemWords;
						if (ea[0])
							shadow_hi[w] = shadow_regs[f119][7:0];
						else
							shadow_lo[w] = shadow_regs[f119][7:0];
						r.st_valid = 1'b1; r.st_address = ea;
						r.st_byte = shadow_regs[f119][7:0];
					end
					OP_LDW: begin
						ea = shadow_regs[f86] + (sign_ext(ins, 6) << 1);
						r.wr_valid = 1'b1; r.wr_index = f119; r.wr_value = fetch_word(ea);
					end
					OP_LEA: begin
						r.wr_valid = 1'b1; r.wr_index = f119;
						r.wr_value = pc2 + (sign_ext(ins, 9) << 1);
					end
					OP_TRAP: begin
						r.wr_valid = 1'b1; r.wr_index = 3'd7; r.wr_value = pc2;
						shadow_pc = fetch_word({7'd0, ins[7:0], 1'b0});
					end
					default: ;
				endcase
				if (r.wr_valid) begin
					shadow_regs[r.wr_index] = r.wr_value;
					if (op != OP_TRAP)
						shadow_nzp = nzp_of(r.wr_value);
				end
			end
		end
		r.pc = shadow_pc;
		{r.n, r.z, r.p} = shadow_nzp;
		return r;
	endfunction

	function automatic command_word_t make_word(input logic [1:0] c, input logic [15:0] a,
						   input logic [15:0] d);
		command_word_t cw;
		cw.cmd = c; cw.addr = a; cw.data = d;
		return cw;
	endfunction

	// write an instruction at pc, point the pc at it, execute it
	task automatic queue_instr(input logic [15:0] pc, input logic [15:0] ins);
		pending_words.push_back(make_word(CMD_WRITE, pc, ins));
		pending_words.push_back(make_word(CMD_SETPC, pc, 16'($urandom)));
		pending_words.push_back(make_word(CMD_EXEC, 16'($urandom), 16'($urandom)));
	endtask

	// driver: hold a word until busy is low at an edge, idle at random
	always @(posedge clk or negedge arst_n) begin
		command_word_t cw;
		if (!arst_n) begin
			start <= 1'b0;
			command <= '0;
			address <= '0;
			data_word <= '0;
		end else if (!(start && busy)) begin
			if (start)
				expected_results.push_back(predict_step({command, address, data_word}));
			if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
				cw = pending_words.pop_front();
				start <= 1'b1;
				command <= cw.cmd;
				address <= cw.addr;
				data_word <= cw.data;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: results last a single cycle, compare on every done
	always @(posedge clk) begin
		step_result_t got, exp_r;
		if (arst_n && done) begin
			got = '{program_counter, flag_negative, flag_zero, flag_positive,
				reg_write_valid, reg_write_index, reg_write_value,
				store_valid, store_address, store_byte, halted};
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected: %p", $time, got);
				failures++;
			end else begin
				exp_r = expected_results.pop_front();
				if (got !== exp_r) begin
					$display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [15:0] pc, ins;
		int          k;
		failures = 0;
		cycles = 0;
		calm = 1'b0;
		for (int i = 0; i < MemWords; i++) begin
			shadow_lo[i] = 8'd0;
			shadow_hi[i] = 8'd0;
		end
		for (int i = 0; i < 8; i++)
			shadow_regs[i] = 16'd0;
		shadow_pc = 16'd0;
		shadow_nzp = 3'b010;

		// directed: halt at pc 0, unused command, field extremes, every opcode
		pending_words.push_back(make_word(CMD_EXEC, 16'h0000, 16'h0000));
		pending_words.push_back(make_word(2'd3, 16'hFFFF, 16'hFFFF));
		pending_words.push_back(make_word(CMD_WRITE, 16'hFFFF, 16'hFFFF));
		pending_words.push_back(make_word(CMD_WRITE, 16'h0201, 16'h0080));
		queue_instr(16'h1000, {OP_ADD, 3'd1, 3'd0, 1'b1, 5'h1F});
		queue_instr(16'h1002, {OP_AND, 3'd2, 3'd1, 1'b0, 2'b00, 3'd1});
		queue_instr(16'h1004, {OP_LDB, 3'd0, 3'd3, 6'h01});
		queue_instr(16'h1006, {OP_STB, 3'd1, 3'd0, 6'h3F});
		queue_instr(16'h1008, {OP_LDW, 3'd4, 3'd1, 6'h20});
		queue_instr(16'h100A, {OP_LEA, 3'd5, 9'h1FF});
		queue_instr(16'h100C, {OP_BR, 3'b111, 9'h100});
		queue_instr(16'h100E, {OP_TRAP, 4'd0, 8'hFF});
		queue_instr(16'hFFFE, {4'd7, 12'hABC});
		pending_words.push_back(make_word(CMD_EXEC, 16'h0000, 16'h0000));

		// random: mostly short programs of well-formed opcodes, some noise
		while (pending_words.size() < 1900) begin
			k = $urandom_range(99);
			if (k < 8) begin
				pending_words.push_back(make_word(2'($urandom_range(3)), 16'($urandom),
					16'($urandom)));
			end else begin
				pc = $urandom_range(1) ? 16'($urandom) : {4'h2, 7'd0, 4'($urandom), 1'b0};
				if (pc == 16'd0)
					pc = 16'd2;
				pending_words.push_back(make_word(CMD_SETPC, pc, 16'($urandom)));
				for (int j = 0; j < 6; j++) begin
					ins = 16'($urandom);
					case ($urandom_range(8))
						0: ins[15:12] = OP_ADD;
						1: ins[15:12] = OP_AND;
						2: ins[15:12] = OP_BR;
						3: ins[15:12] = OP_LDB;
						4: ins[15:12] = OP_STB;
						5: ins[15:12] = OP_LDW;
						6: ins[15:12] = OP_LEA;
						7: ins[15:12] = OP_TRAP;
						default: ;
					endcase
					pending_words.push_back(make_word(CMD_WRITE, pc + 16'(2 * j), ins));
				end
				for (int j = 0; j < 6; j++)
					pending_words.push_back(make_word(CMD_EXEC, 16'($urandom),
						16'($urandom)));
			end
		end

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// hold a stretch without idling in the middle of the run
		wait (pending_words.size() < 1200);
		calm = 1'b1;
		wait (pending_words.size() < 900);
		calm = 1'b0;
		wait (pending_words.size() == 0 && !start);
		wait (expected_results.size() == 0);
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
